// File: hdl/table_driven_fsm_engine_defines.svh
// Assertion macros for the table-driven FSM engine.
`ifndef TABLE_DRIVEN_FSM_ENGINE_DEFINES_SVH
`define TABLE_DRIVEN_FSM_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FTE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/fte_pkg.sv
package fte_pkg;

    localparam int MAX_EDGES_DEF  = 64;
    localparam int MAX_STEPS_DEF  = 1024;
    localparam int STATE_BITS_DEF = 8;

    // opcodes
    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_STEP    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DUP       = 3'd1;
    localparam logic [2:0] ST_BADLETTER = 3'd2;
    localparam logic [2:0] ST_NONDET    = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;
    localparam logic [2:0] ST_NOEDGE    = 3'd5;
    localparam logic [2:0] ST_LIMIT     = 3'd6;
    localparam logic [2:0] ST_BLOCKED   = 3'd7;

    // letter bounds
    localparam logic [7:0] CH_LO_A = 8'h61;
    localparam logic [7:0] CH_LO_Z = 8'h7a;
    localparam logic [7:0] CH_UP_A = 8'h41;
    localparam logic [7:0] CH_UP_Z = 8'h5a;

    // beat layouts
    localparam int TDATA_W     = 32;
    localparam int IN_OPC_LSB  = 0;
    localparam int IN_FROM_LSB = 2;
    localparam int IN_LTR_LSB  = 10;
    localparam int IN_TO_LSB   = 18;
    localparam int OUT_STS_LSB = 0;
    localparam int OUT_MST_LSB = 3;
    localparam int OUT_STP_LSB = 11;
    localparam int OUT_EDG_LSB = 22;
    localparam int OUT_USED    = 29;

    // microprogram addresses
    localparam logic [3:0] U_FETCH    = 4'd0;
    localparam logic [3:0] U_ADD0     = 4'd1;
    localparam logic [3:0] U_ADD1     = 4'd2;
    localparam logic [3:0] U_ADD_SCAN = 4'd3;
    localparam logic [3:0] U_ADD_RES  = 4'd4;
    localparam logic [3:0] U_ADD_DUP  = 4'd5;
    localparam logic [3:0] U_STP0     = 4'd6;
    localparam logic [3:0] U_STP1     = 4'd7;
    localparam logic [3:0] U_STP_SCAN = 4'd8;
    localparam logic [3:0] U_STP_RES  = 4'd9;
    localparam logic [3:0] U_RESTART  = 4'd10;
    localparam logic [3:0] U_CLEAR    = 4'd11;
    localparam logic [3:0] U_DONE     = 4'd12;

    // branch conditions
    localparam logic [3:0] C_ALWAYS  = 4'd0;
    localparam logic [3:0] C_IN      = 4'd1;
    localparam logic [3:0] C_FULL    = 4'd2;
    localparam logic [3:0] C_BAD     = 4'd3;
    localparam logic [3:0] C_BLOCKED = 4'd4;
    localparam logic [3:0] C_LIMIT   = 4'd5;
    localparam logic [3:0] C_STOP    = 4'd6;
    localparam logic [3:0] C_END     = 4'd7;
    localparam logic [3:0] C_SAMEDST = 4'd8;
    localparam logic [3:0] C_OUTFREE = 4'd9;

    // datapath actions
    localparam logic [3:0] A_NONE    = 4'd0;
    localparam logic [3:0] A_LOAD    = 4'd1;
    localparam logic [3:0] A_FULL    = 4'd2;
    localparam logic [3:0] A_BAD     = 4'd3;
    localparam logic [3:0] A_DUP     = 4'd4;
    localparam logic [3:0] A_NONDET  = 4'd5;
    localparam logic [3:0] A_APPEND  = 4'd6;
    localparam logic [3:0] A_NEXT    = 4'd7;
    localparam logic [3:0] A_BLOCKED = 4'd8;
    localparam logic [3:0] A_LIMIT   = 4'd9;
    localparam logic [3:0] A_NOEDGE  = 4'd10;
    localparam logic [3:0] A_MOVE    = 4'd11;
    localparam logic [3:0] A_RESTART = 4'd12;
    localparam logic [3:0] A_CLEAR   = 4'd13;
    localparam logic [3:0] A_EMIT    = 4'd14;

    typedef struct packed {
        logic [3:0] cond;
        logic [3:0] act_t;
        logic [3:0] tgt_t;
        logic [3:0] act_f;
        logic [3:0] tgt_f;
        logic       key_cur;   // scan key: current state instead of edge source
        logic       disp;      // taken branch jumps by opcode
    } uword_t;

    typedef struct packed {
        logic [3:0] act;
        logic       key_cur;
    } dp_ctrl_t;

    typedef struct packed {
        logic full;
        logic bad_letter;
        logic blocked;
        logic at_limit;
        logic scan_stop;
        logic at_end;
        logic same_dst;
        logic out_free;
    } dp_flags_t;

    function automatic uword_t uw(input logic [3:0] cond, input logic [3:0] act_t,
                                  input logic [3:0] tgt_t, input logic [3:0] act_f,
                                  input logic [3:0] tgt_f, input logic key_cur,
                                  input logic disp);
        uword_t w;
        w.cond    = cond;
        w.act_t   = act_t;
        w.tgt_t   = tgt_t;
        w.act_f   = act_f;
        w.tgt_f   = tgt_f;
        w.key_cur = key_cur;
        w.disp    = disp;
        return w;
    endfunction

    // control store
    function automatic uword_t ucode(input logic [3:0] addr);
        uword_t w;
        unique case (addr)
            U_FETCH:    w = uw(C_IN,      A_LOAD,    U_FETCH,   A_NONE,    U_FETCH,    1'b0, 1'b1);
            U_ADD0:     w = uw(C_FULL,    A_FULL,    U_DONE,    A_NONE,    U_ADD1,     1'b0, 1'b0);
            U_ADD1:     w = uw(C_BAD,     A_BAD,     U_DONE,    A_NONE,    U_ADD_SCAN, 1'b0, 1'b0);
            U_ADD_SCAN: w = uw(C_STOP,    A_NONE,    U_ADD_RES, A_NEXT,    U_ADD_SCAN, 1'b0, 1'b0);
            U_ADD_RES:  w = uw(C_END,     A_APPEND,  U_DONE,    A_NONE,    U_ADD_DUP,  1'b0, 1'b0);
            U_ADD_DUP:  w = uw(C_SAMEDST, A_DUP,     U_DONE,    A_NONDET,  U_DONE,     1'b0, 1'b0);
            U_STP0:     w = uw(C_BLOCKED, A_BLOCKED, U_DONE,    A_NONE,    U_STP1,     1'b1, 1'b0);
            U_STP1:     w = uw(C_LIMIT,   A_LIMIT,   U_DONE,    A_NONE,    U_STP_SCAN, 1'b1, 1'b0);
            U_STP_SCAN: w = uw(C_STOP,    A_NONE,    U_STP_RES, A_NEXT,    U_STP_SCAN, 1'b1, 1'b0);
            U_STP_RES:  w = uw(C_END,     A_NOEDGE,  U_DONE,    A_MOVE,    U_DONE,     1'b1, 1'b0);
            U_RESTART:  w = uw(C_ALWAYS,  A_RESTART, U_DONE,    A_NONE,    U_DONE,     1'b0, 1'b0);
            U_CLEAR:    w = uw(C_ALWAYS,  A_CLEAR,   U_DONE,    A_NONE,    U_DONE,     1'b0, 1'b0);
            U_DONE:     w = uw(C_OUTFREE, A_EMIT,    U_FETCH,   A_NONE,    U_DONE,     1'b0, 1'b0);
            default:    w = uw(C_ALWAYS,  A_NONE,    U_FETCH,   A_NONE,    U_FETCH,    1'b0, 1'b0);
        endcase
        return w;
    endfunction

    function automatic logic [3:0] dispatch(input logic [1:0] opcode);
        logic [3:0] a;
        unique case (opcode)
            OP_ADD:     a = U_ADD0;
            OP_STEP:    a = U_STP0;
            OP_RESTART: a = U_RESTART;
            OP_CLEAR:   a = U_CLEAR;
            default:    a = U_FETCH;
        endcase
        return a;
    endfunction

endpackage

// File: hdl/fte_useq.sv
module fte_useq
    import fte_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] opcode,
    input  dp_flags_t  flags,
    output dp_ctrl_t   ctrl,
    output logic       in_ready
);

    logic [3:0] upc_reg;
    logic [3:0] upc_next;
    uword_t     word;
    logic       taken;

    assign word     = ucode(upc_reg);
    assign in_ready = (upc_reg == U_FETCH);

    always_comb
    begin
        unique case (word.cond)
            C_ALWAYS:  taken = 1'b1;
            C_IN:      taken = in_valid;
            C_FULL:    taken = flags.full;
            C_BAD:     taken = flags.bad_letter;
            C_BLOCKED: taken = flags.blocked;
            C_LIMIT:   taken = flags.at_limit;
            C_STOP:    taken = flags.scan_stop;
            C_END:     taken = flags.at_end;
            C_SAMEDST: taken = flags.same_dst;
            C_OUTFREE: taken = flags.out_free;
            default:   taken = 1'b0;
        endcase
    end

    always_comb
    begin
        ctrl.key_cur = word.key_cur;
        if (taken)
        begin
            ctrl.act = word.act_t;
            upc_next = word.disp ? dispatch(opcode) : word.tgt_t;
        end
        else
        begin
            ctrl.act = word.act_f;
            upc_next = word.tgt_f;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_FETCH;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

// File: hdl/fte_dpath.sv
module fte_dpath
    import fte_pkg::*;
#(
    parameter int MAX_EDGES  = MAX_EDGES_DEF,
    parameter int MAX_STEPS  = MAX_STEPS_DEF,
    parameter int STATE_BITS = STATE_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_ctrl_t   ctrl,
    input  logic [7:0] in_from,
    input  logic [7:0] in_letter,
    input  logic [7:0] in_to,
    input  logic       out_ready,
    output dp_flags_t  flags,
    output logic       out_valid,
    output logic [2:0] out_status,
    output logic [7:0] out_state,
    output logic [10:0] out_steps,
    output logic [6:0] out_edges
);

    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int SW = $clog2(MAX_STEPS + 1);
    localparam int EW = 2 * STATE_BITS + 8;

    // entry: {source, letter, target}
    logic [EW-1:0]         mem [MAX_EDGES];
    logic [EW-1:0]         rdata_reg;
    logic [EW-1:0]         wdata;
    logic                  we;

    logic [STATE_BITS-1:0] from_reg, from_next;
    logic [STATE_BITS-1:0] to_reg, to_next;
    logic [7:0]            ltr_reg, ltr_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [STATE_BITS-1:0] cur_reg, cur_next;
    logic [SW-1:0]         stp_reg, stp_next;
    logic                  lf_reg, lf_next;
    logic                  halt_reg, halt_next;
    logic [2:0]            sts_reg, sts_next;
    logic                  ovld_reg, ovld_next;
    logic [2:0]            osts_reg;
    logic [7:0]            ost_reg;
    logic [10:0]           ostp_reg;
    logic [6:0]            oedg_reg;

    logic [STATE_BITS-1:0] rd_src, rd_dst, key;
    logic [7:0]            rd_sym;
    logic                  hit;

    assign rd_src = rdata_reg[EW-1 -: STATE_BITS];
    assign rd_sym = rdata_reg[STATE_BITS +: 8];
    assign rd_dst = rdata_reg[STATE_BITS-1:0];
    assign key    = ctrl.key_cur ? cur_reg : from_reg;
    assign hit    = (rd_src == key) && (rd_sym == ltr_reg);
    assign wdata  = {from_reg, ltr_reg, to_reg};

    assign flags.full       = (cnt_reg >= CW'(MAX_EDGES));
    assign flags.bad_letter = !(((ltr_reg >= CH_LO_A) && (ltr_reg <= CH_LO_Z)) ||
                                ((ltr_reg >= CH_UP_A) && (ltr_reg <= CH_UP_Z)));
    assign flags.blocked    = lf_reg || halt_reg;
    assign flags.at_limit   = (stp_reg >= SW'(MAX_STEPS));
    assign flags.at_end     = (idx_reg == cnt_reg);
    assign flags.scan_stop  = flags.at_end || hit;
    assign flags.same_dst   = (rd_dst == to_reg);
    assign flags.out_free   = !ovld_reg || out_ready;

    always_comb
    begin
        from_next = from_reg;
        to_next   = to_reg;
        ltr_next  = ltr_reg;
        idx_next  = idx_reg;
        cnt_next  = cnt_reg;
        cur_next  = cur_reg;
        stp_next  = stp_reg;
        lf_next   = lf_reg;
        halt_next = halt_reg;
        sts_next  = sts_reg;
        we        = 1'b0;
        ovld_next = (ovld_reg && !out_ready);
        case (ctrl.act)
            A_LOAD:
            begin
                from_next = STATE_BITS'(in_from);
                to_next   = STATE_BITS'(in_to);
                ltr_next  = in_letter;
                idx_next  = '0;
            end
            A_FULL:    sts_next = ST_FULL;
            A_BAD:
            begin
                sts_next = ST_BADLETTER;
                lf_next  = 1'b1;
            end
            A_DUP:     sts_next = ST_DUP;
            A_NONDET:
            begin
                sts_next = ST_NONDET;
                lf_next  = 1'b1;
            end
            A_APPEND:
            begin
                we       = 1'b1;
                cnt_next = cnt_reg + CW'(1);
                sts_next = ST_OK;
            end
            A_NEXT:    idx_next = idx_reg + CW'(1);
            A_BLOCKED: sts_next = ST_BLOCKED;
            A_LIMIT:   sts_next = ST_LIMIT;
            A_NOEDGE:
            begin
                sts_next  = ST_NOEDGE;
                halt_next = 1'b1;
            end
            A_MOVE:
            begin
                cur_next = rd_dst;
                stp_next = stp_reg + SW'(1);
                sts_next = ST_OK;
            end
            A_RESTART:
            begin
                cur_next  = '0;
                stp_next  = '0;
                halt_next = 1'b0;
                sts_next  = ST_OK;
            end
            A_CLEAR:
            begin
                cnt_next = '0;
                lf_next  = 1'b0;
                sts_next = ST_OK;
            end
            A_EMIT:    ovld_next = 1'b1;
            default:   ;
        endcase
    end

    // table: at most one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[cnt_reg[AW-1:0]] <= wdata;
        end
        rdata_reg <= mem[idx_next[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        from_reg <= from_next;
        to_reg   <= to_next;
        ltr_reg  <= ltr_next;
        sts_reg  <= sts_next;
        if (ctrl.act == A_EMIT)
        begin
            osts_reg <= sts_reg;
            ost_reg  <= 8'(cur_reg);
            ostp_reg <= 11'(stp_reg);
            oedg_reg <= 7'(cnt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            cnt_reg  <= '0;
            cur_reg  <= '0;
            stp_reg  <= '0;
            lf_reg   <= 1'b0;
            halt_reg <= 1'b0;
            ovld_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            cnt_reg  <= cnt_next;
            cur_reg  <= cur_next;
            stp_reg  <= stp_next;
            lf_reg   <= lf_next;
            halt_reg <= halt_next;
            ovld_reg <= ovld_next;
        end
    end

    assign out_valid  = ovld_reg;
    assign out_status = osts_reg;
    assign out_state  = ost_reg;
    assign out_steps  = ostp_reg;
    assign out_edges  = oedg_reg;

endmodule

// File: hdl/table_driven_fsm_engine.sv
// Order of words: restart and clear run their action word, then the done step; a full
//   table or a blocked step ends at the first check, a bad letter or the step limit at the
//   second; a scanning add or step walks the stored edges in order, then a result word.
// Handshake: the next beat is taken in the cycle m_tvalid rises; a result still waiting
//   on m_tready holds the next one at the done step.
// Reset: rst_n async low; empties table, zeroes state/step count, clears error flags.
`include "table_driven_fsm_engine_defines.svh"

module table_driven_fsm_engine
    import fte_pkg::*;
#(
    parameter int MAX_EDGES  = MAX_EDGES_DEF,
    parameter int MAX_STEPS  = MAX_STEPS_DEF,
    parameter int STATE_BITS = STATE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    // opcode[1:0], from_state[9:2], letter[17:10], to_state[25:18], zero pad
    input  logic [TDATA_W-1:0] s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    // status[2:0], machine_state[10:3], steps_taken[21:11], edges_held[28:22], zero pad
    output logic [TDATA_W-1:0] m_tdata
);

    // Microcoded control: fte_useq walks a 13-word control store, one word per
    // cycle. Each word tests one condition and picks one of two (action, next
    // address) pairs. The fetch word dispatches on the opcode of the accepted beat.
    //
    // Scan loop: the datapath presents table entry idx on its registered read
    // port; the scan word stops on a match or on idx == edge count, else bumps idx.
    // A result word then sorts out append / dup / nondet (add) or move / no-edge
    // (step). The done word parks the result in the output register, so a new
    // beat can be taken while the previous result waits for m_tready.

    dp_ctrl_t   ctrl;
    dp_flags_t  flags;
    logic [2:0] out_status;
    logic [7:0] out_state;
    logic [10:0] out_steps;
    logic [6:0] out_edges;

    fte_useq u_useq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .opcode   (s_tdata[IN_OPC_LSB +: 2]),
        .flags    (flags),
        .ctrl     (ctrl),
        .in_ready (s_tready)
    );

    fte_dpath #(
        .MAX_EDGES  (MAX_EDGES),
        .MAX_STEPS  (MAX_STEPS),
        .STATE_BITS (STATE_BITS)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .in_from    (s_tdata[IN_FROM_LSB +: 8]),
        .in_letter  (s_tdata[IN_LTR_LSB +: 8]),
        .in_to      (s_tdata[IN_TO_LSB +: 8]),
        .out_ready  (m_tready),
        .flags      (flags),
        .out_valid  (m_tvalid),
        .out_status (out_status),
        .out_state  (out_state),
        .out_steps  (out_steps),
        .out_edges  (out_edges)
    );

    assign m_tdata = {{(TDATA_W - OUT_USED){1'b0}}, out_edges, out_steps, out_state,
                      out_status};

    // sequencer must leave the fetch word right after taking a beat
    `FTE_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
                     "fetch repeated after accept")
    // a step-limit result must report the limit as the step count
    `FTE_ASSERT_NOW(a_limit_count, m_tvalid && (out_status == ST_LIMIT),
                    out_steps == 11'(MAX_STEPS), "limit status with wrong step count")
    // a table-full result must report a full table
    `FTE_ASSERT_NOW(a_full_count, m_tvalid && (out_status == ST_FULL),
                    out_edges == 7'(MAX_EDGES), "full status with wrong edge count")

endmodule
